### src/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked only outside reset.
`define SDP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("predictor assertion failed");

// Assertion that is checked during reset too.
`define SDP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("predictor assertion failed");

`endif

### src/sdp_pkg.sv
// Shared constants of the sampling dead-block predictor.
// No dependencies.
package sdp_pkg;

    localparam int TAG_BITS     = 16;
    localparam int TRACE_BITS   = 16;
    localparam int TID_BITS     = 4;
    localparam int SET_IN_BITS  = 7;
    localparam int WAY_BITS     = 4;
    localparam int THRESH_BITS  = 4;
    localparam int NUM_TABLES   = 3;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 4'd8;

    localparam logic [31:0] SEED_A0 = 32'hfeedface;
    localparam logic [31:0] SEED_B0 = 32'hdeadb10c;
    localparam logic [31:0] SEED_A1 = 32'hc001d00d;
    localparam logic [31:0] SEED_B1 = 32'hfade2b1c;
    localparam int SHIFT_HI = 13;
    localparam int SHIFT_LO = 8;

endpackage

### src/sdp_if.sv
// Request and response channel interfaces of the predictor.
// Depends on sdp_pkg.
interface sdp_req_if;
    logic                               valid;
    logic                               ready;
    logic [sdp_pkg::TID_BITS-1:0]       thread_id;
    logic [sdp_pkg::SET_IN_BITS-1:0]    set_index;
    logic [sdp_pkg::TAG_BITS-1:0]       block_tag;
    logic [sdp_pkg::TRACE_BITS-1:0]     pc_bits;

    modport source (output valid, thread_id, set_index, block_tag, pc_bits, input ready);
    modport sink (input valid, thread_id, set_index, block_tag, pc_bits, output ready);
endinterface

interface sdp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           sampler_hit;
    logic [sdp_pkg::WAY_BITS-1:0]   chosen_way;
    logic                           predicted_dead;

    modport source (output valid, sampler_hit, chosen_way, predicted_dead, input ready);
    modport sink (input valid, sampler_hit, chosen_way, predicted_dead, output ready);
endinterface

### src/sdp_hash.sv
// Two-stage pipelined hash giving one counter slot per predictor table.
// Depends on sdp_pkg.
module sdp_hash #(
    parameter int INDEX_BITS = 12
) (
    input  logic                                            i_clk,
    input  logic [31:0]                                     i_key,
    output logic [sdp_pkg::NUM_TABLES-1:0][INDEX_BITS-1:0]  o_slot
);

    logic [31:0] n_a0, n_b0, n_a1, n_b1;
    logic [31:0] r_a0, r_b0, r_a1, r_b1;
    logic [31:0] c0, c1;
    logic [31:0] sums [sdp_pkg::NUM_TABLES];
    logic [sdp_pkg::NUM_TABLES-1:0][INDEX_BITS-1:0] n_slot, r_slot;

    // First half of both scrambles: the a and b mixing steps.
    always_comb begin
        n_a0 = (sdp_pkg::SEED_A0 - sdp_pkg::SEED_B0 - i_key) ^ (i_key >> sdp_pkg::SHIFT_HI);
        n_b0 = (sdp_pkg::SEED_B0 - i_key - n_a0) ^ (n_a0 >> sdp_pkg::SHIFT_LO);
        n_a1 = (sdp_pkg::SEED_A1 - sdp_pkg::SEED_B1 - i_key) ^ (i_key >> sdp_pkg::SHIFT_HI);
        n_b1 = (sdp_pkg::SEED_B1 - i_key - n_a1) ^ (n_a1 >> sdp_pkg::SHIFT_LO);
    end

    always_comb begin
        c0 = ((r_b0 - r_a0) - r_b0) ^ (r_b0 >> sdp_pkg::SHIFT_HI);
        c1 = ((r_b1 - r_a1) - r_b1) ^ (r_b1 >> sdp_pkg::SHIFT_HI);
        for (int t = 0; t < sdp_pkg::NUM_TABLES; t++) begin
            sums[t]   = c0 + (c1 >> t);
            n_slot[t] = sums[t][INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0   <= n_a0;
        r_b0   <= n_b0;
        r_a1   <= n_a1;
        r_b1   <= n_b1;
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

### src/sdp_ctr_mem.sv
// Three tables of saturating counters, one read and one write port each.
// Depends on sdp_pkg.
module sdp_ctr_mem #(
    parameter int INDEX_BITS   = 12,
    parameter int COUNTER_BITS = 2
) (
    input  logic                                              i_clk,
    input  logic                                              i_rd_en,
    input  logic [sdp_pkg::NUM_TABLES-1:0][INDEX_BITS-1:0]    i_rd_addr,
    output logic [sdp_pkg::NUM_TABLES-1:0][COUNTER_BITS-1:0]  o_rd_data,
    input  logic                                              i_wr_en,
    input  logic [sdp_pkg::NUM_TABLES-1:0][INDEX_BITS-1:0]    i_wr_addr,
    input  logic [sdp_pkg::NUM_TABLES-1:0][COUNTER_BITS-1:0]  i_wr_data
);

    localparam int TABLE_SIZE = 1 << INDEX_BITS;

    for (genvar t = 0; t < sdp_pkg::NUM_TABLES; t++) begin : g_table
        logic [COUNTER_BITS-1:0] mem [TABLE_SIZE];
        logic [COUNTER_BITS-1:0] r_data;

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                mem[i_wr_addr[t]] <= i_wr_data[t];
            end
            if (i_rd_en) begin
                r_data <= mem[i_rd_addr[t]];
            end
        end

        assign o_rd_data[t] = r_data;
    end

endmodule

### src/sampling_dead_block_predictor.sv
// Each request passes through the S_RD, S_SET, S_TH1, S_TH2, S_TRD, S_TWR, S_PRD
// and S_FIN states: the sampler set read, the two-stage hash run twice and the
// counter read-modify-write on one port per table. The response is registered as
// S_FIN ends, once the output is free; no new request is taken before that.
// Reset: a sweep clears the sampler and counter memories, taking no requests.
module sampling_dead_block_predictor #(
    parameter int SAMPLER_SETS = 128,
    parameter int WAYS         = 12,
    parameter int INDEX_BITS   = 12,
    parameter int COUNTER_BITS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sdp_req_if.sink                           i_req,
    sdp_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [sdp_pkg::THRESH_BITS-1:0]   i_cfg_wdata
);

    localparam int NT         = sdp_pkg::NUM_TABLES;
    localparam int TAGB       = sdp_pkg::TAG_BITS;
    localparam int TRB        = sdp_pkg::TRACE_BITS;
    localparam int WB         = sdp_pkg::WAY_BITS;
    localparam int RANK_BITS  = $clog2(WAYS);
    localparam int SET_BITS   = (SAMPLER_SETS > 1) ? $clog2(SAMPLER_SETS) : 1;
    localparam int TABLE_SIZE = 1 << INDEX_BITS;
    localparam int CLR_LEN    = (SAMPLER_SETS > TABLE_SIZE) ? SAMPLER_SETS : TABLE_SIZE;
    localparam int CLR_BITS   = $clog2(CLR_LEN);
    localparam int RECIP_SH   = 20;
    localparam int RECIP      = ((1 << RECIP_SH) + SAMPLER_SETS - 1) / SAMPLER_SETS;
    localparam int SUM_BITS   = COUNTER_BITS + 2;
    localparam int CMP_BITS   = (SUM_BITS > sdp_pkg::THRESH_BITS) ? SUM_BITS
                                                                  : sdp_pkg::THRESH_BITS;
    localparam logic [COUNTER_BITS-1:0] CTR_TOP = {COUNTER_BITS{1'b1}};

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_RD   = 10'b0000000100,
        S_SET  = 10'b0000001000,
        S_TH1  = 10'b0000010000,
        S_TH2  = 10'b0000100000,
        S_TRD  = 10'b0001000000,
        S_TWR  = 10'b0010000000,
        S_PRD  = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [sdp_pkg::THRESH_BITS-1:0] r_thresh;
    logic [CLR_BITS-1:0]             r_clr;

    // Request fields held for the whole item.
    logic [sdp_pkg::TID_BITS-1:0]    r_tid;
    logic [sdp_pkg::SET_IN_BITS-1:0] r_set_raw;
    logic [sdp_pkg::SET_IN_BITS-1:0] r_quot;
    logic [TAGB-1:0]                 r_tag;
    logic [TRB-1:0]                  r_trace;
    logic [SET_BITS-1:0]             r_set;
    logic [31:0]                     r_hkey;
    logic                            r_hit;
    logic [WB-1:0]                   r_way;
    logic [NT-1:0][INDEX_BITS-1:0]   r_pslot;
    logic [NT-1:0][INDEX_BITS-1:0]   r_tslot;

    logic [27:0] quot_full;
    logic [31:0] set_full;
    logic [SET_BITS-1:0] set_idx;

    // Sampler memory, one row per set.
    logic [WAYS-1:0]                 m_valid [SAMPLER_SETS];
    logic [WAYS-1:0][TAGB-1:0]       m_tag   [SAMPLER_SETS];
    logic [WAYS-1:0][TRB-1:0]        m_trace [SAMPLER_SETS];
    logic [WAYS-1:0]                 m_dead  [SAMPLER_SETS];
    logic [WAYS-1:0][RANK_BITS-1:0]  m_rank  [SAMPLER_SETS];

    logic [WAYS-1:0]                 r_rd_valid;
    logic [WAYS-1:0][TAGB-1:0]       r_rd_tag;
    logic [WAYS-1:0][TRB-1:0]        r_rd_trace;
    logic [WAYS-1:0]                 r_rd_dead;
    logic [WAYS-1:0][RANK_BITS-1:0]  r_rd_rank;

    logic                            s_we;
    logic [SET_BITS-1:0]             s_waddr;
    logic [WAYS-1:0]                 s_wvalid;
    logic [WAYS-1:0][TAGB-1:0]       s_wtag;
    logic [WAYS-1:0][TRB-1:0]        s_wtrace;
    logic [WAYS-1:0]                 s_wdead;
    logic [WAYS-1:0][RANK_BITS-1:0]  s_wrank;

    logic [NT-1:0][INDEX_BITS-1:0]   hash_slot;
    logic                            c_rd_en;
    logic [NT-1:0][INDEX_BITS-1:0]   c_rd_addr;
    logic [NT-1:0][COUNTER_BITS-1:0] c_rd_data;
    logic                            c_we;
    logic [NT-1:0][INDEX_BITS-1:0]   c_waddr;
    logic [NT-1:0][COUNTER_BITS-1:0] c_wdata;

    logic                            hit;
    logic [WB-1:0]                   way_sel;
    logic [TRB-1:0]                  old_trace;
    logic [SUM_BITS-1:0]             ctr_sum;
    logic                            pred;
    logic [RANK_BITS-1:0]            sel_rank;
    logic                            clr_sets, clr_ctrs, clr_last, fin_go;

    logic r_out_valid, r_out_hit, r_out_dead;
    logic [WB-1:0] r_out_way;

    assign quot_full = 28'(i_req.set_index) * 28'(RECIP);
    assign set_full  = 32'(r_set_raw) - 32'(r_quot) * 32'(SAMPLER_SETS);
    assign set_idx   = set_full[SET_BITS-1:0];

    assign clr_sets = ({1'b0, r_clr} < (CLR_BITS + 1)'(SAMPLER_SETS));
    assign clr_ctrs = ({1'b0, r_clr} < (CLR_BITS + 1)'(TABLE_SIZE));
    assign clr_last = (r_clr == CLR_BITS'(CLR_LEN - 1));
    assign fin_go   = !r_out_valid || o_rsp.ready;

    // Hit search and victim choice on the set row.
    always_comb begin
        logic inv_f, dead_f, lru_f;
        logic [WB-1:0] hit_w, inv_w, dead_w, lru_w;
        hit    = 1'b0;
        inv_f  = 1'b0;
        dead_f = 1'b0;
        lru_f  = 1'b0;
        hit_w  = '0;
        inv_w  = '0;
        dead_w = '0;
        lru_w  = WB'(WAYS - 1);
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rd_valid[w] && r_rd_tag[w] == r_tag) begin
                hit   = 1'b1;
                hit_w = WB'(w);
            end
            if (!r_rd_valid[w]) begin
                inv_f = 1'b1;
                inv_w = WB'(w);
            end
            if (r_rd_dead[w]) begin
                dead_f = 1'b1;
                dead_w = WB'(w);
            end
            if (r_rd_rank[w] == RANK_BITS'(WAYS - 1)) begin
                lru_f = 1'b1;
                lru_w = WB'(w);
            end
        end
        if (hit) begin
            way_sel = hit_w;
        end else if (inv_f) begin
            way_sel = inv_w;
        end else if (dead_f) begin
            way_sel = dead_w;
        end else begin
            way_sel = lru_w;
        end
        old_trace = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (way_sel == WB'(w)) begin
                old_trace = r_rd_trace[w];
            end
        end
    end

    // Counter sum for the new trace and the threshold compare.
    always_comb begin
        ctr_sum = '0;
        for (int t = 0; t < NT; t++) begin
            ctr_sum = ctr_sum + SUM_BITS'(c_rd_data[t]);
        end
        pred = (CMP_BITS'(ctr_sum) >= CMP_BITS'(r_thresh));
    end

    // Sampler write: reset row during the sweep, updated row at the end of an item.
    always_comb begin
        sel_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_way == WB'(w)) begin
                sel_rank = r_rd_rank[w];
            end
        end
        s_we    = 1'b0;
        s_waddr = r_set;
        if (r_state == S_CLR) begin
            s_we    = clr_sets;
            s_waddr = r_clr[SET_BITS-1:0];
            for (int w = 0; w < WAYS; w++) begin
                s_wvalid[w] = 1'b0;
                s_wtag[w]   = '0;
                s_wtrace[w] = '0;
                s_wdead[w]  = 1'b0;
                s_wrank[w]  = RANK_BITS'(w);
            end
        end else begin
            s_we = (r_state == S_FIN) && fin_go;
            for (int w = 0; w < WAYS; w++) begin
                if (r_way == WB'(w)) begin
                    s_wvalid[w] = 1'b1;
                    s_wtag[w]   = r_tag;
                    s_wtrace[w] = r_trace;
                    s_wdead[w]  = pred;
                    s_wrank[w]  = '0;
                end else begin
                    s_wvalid[w] = r_rd_valid[w];
                    s_wtag[w]   = r_rd_tag[w];
                    s_wtrace[w] = r_rd_trace[w];
                    s_wdead[w]  = r_rd_dead[w];
                    s_wrank[w]  = (r_rd_rank[w] < sel_rank) ? r_rd_rank[w] + 1'b1
                                                            : r_rd_rank[w];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            m_valid[s_waddr] <= s_wvalid;
            m_tag[s_waddr]   <= s_wtag;
            m_trace[s_waddr] <= s_wtrace;
            m_dead[s_waddr]  <= s_wdead;
            m_rank[s_waddr]  <= s_wrank;
        end
        if (r_state == S_RD) begin
            r_rd_valid <= m_valid[set_idx];
            r_rd_tag   <= m_tag[set_idx];
            r_rd_trace <= m_trace[set_idx];
            r_rd_dead  <= m_dead[set_idx];
            r_rd_rank  <= m_rank[set_idx];
        end
    end

    // Counter accesses: train on the old trace, then read for the new one.
    always_comb begin
        c_rd_en   = (r_state == S_TRD) || (r_state == S_PRD);
        c_rd_addr = (r_state == S_TRD) ? hash_slot : r_pslot;
        c_we      = 1'b0;
        c_waddr   = r_tslot;
        c_wdata   = '0;
        if (r_state == S_CLR) begin
            c_we = clr_ctrs;
            for (int t = 0; t < NT; t++) begin
                c_waddr[t] = r_clr[INDEX_BITS-1:0];
            end
        end else if (r_state == S_TWR) begin
            c_we = 1'b1;
            for (int t = 0; t < NT; t++) begin
                if (!r_hit) begin
                    c_wdata[t] = (c_rd_data[t] == CTR_TOP) ? c_rd_data[t]
                                                           : c_rd_data[t] + 1'b1;
                end else if ((t & 1) != 0) begin
                    c_wdata[t] = c_rd_data[t] >> 1;
                end else begin
                    c_wdata[t] = (c_rd_data[t] == '0) ? c_rd_data[t]
                                                      : c_rd_data[t] - 1'b1;
                end
            end
        end
    end

    sdp_hash #(
        .INDEX_BITS (INDEX_BITS)
    ) u_hash (
        .i_clk  (i_clk),
        .i_key  (r_hkey),
        .o_slot (hash_slot)
    );

    sdp_ctr_mem #(
        .INDEX_BITS   (INDEX_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_ctr (
        .i_clk     (i_clk),
        .i_rd_en   (c_rd_en),
        .i_rd_addr (c_rd_addr),
        .o_rd_data (c_rd_data),
        .i_wr_en   (c_we),
        .i_wr_addr (c_waddr),
        .i_wr_data (c_wdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  n_state = clr_last ? S_IDLE : S_CLR;
            S_IDLE: n_state = i_req.valid ? S_RD : S_IDLE;
            S_RD:   n_state = S_SET;
            S_SET:  n_state = S_TH1;
            S_TH1:  n_state = S_TH2;
            S_TH2:  n_state = S_TRD;
            S_TRD:  n_state = S_TWR;
            S_TWR:  n_state = S_PRD;
            S_PRD:  n_state = S_FIN;
            S_FIN:  n_state = fin_go ? S_IDLE : S_FIN;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_thresh    <= sdp_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (r_state == S_FIN && fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_tid     <= i_req.thread_id;
            r_set_raw <= i_req.set_index;
            r_quot    <= quot_full[RECIP_SH +: sdp_pkg::SET_IN_BITS];
            r_tag     <= i_req.block_tag;
            r_trace   <= i_req.pc_bits;
            r_hkey    <= 32'(i_req.pc_bits) ^ (32'(i_req.thread_id) << 2);
        end
        if (r_state == S_RD) begin
            r_set <= set_idx;
        end
        if (r_state == S_SET) begin
            r_hit  <= hit;
            r_way  <= way_sel;
            r_hkey <= 32'(old_trace) ^ (32'(r_tid) << 2);
        end
        if (r_state == S_TH1) begin
            r_pslot <= hash_slot;
        end
        if (r_state == S_TRD) begin
            r_tslot <= hash_slot;
        end
        if (r_state == S_FIN && fin_go) begin
            r_out_hit  <= r_hit;
            r_out_way  <= r_way;
            r_out_dead <= pred;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.sampler_hit    = r_out_hit;
    assign o_rsp.chosen_way     = r_out_way;
    assign o_rsp.predicted_dead = r_out_dead;

endmodule

### src/sdp_checker.sv
// Port-level checks of the predictor, bound to the top level.
// Depends on sdp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdp_checker #(
    parameter int WAYS = 12
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [sdp_pkg::WAY_BITS-1:0]  i_rsp_way
);

    // A response that is not taken stays offered.
    `SDP_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)

    // Requests are worked one at a time, so a taken request drops ready.
    `SDP_ASSERT(a_one_busy, i_clk, i_rst_n, i_req_valid && i_req_ready |=> !i_req_ready)

    `SDP_ASSERT(a_way_range, i_clk, i_rst_n, i_rsp_valid |-> i_rsp_way < WAYS)

    // Reset empties the output and starts the clearing sweep.
    `SDP_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_rsp_valid && !i_req_ready)

endmodule

bind sampling_dead_block_predictor sdp_checker #(
    .WAYS (WAYS)
) u_sdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_way   (o_rsp.chosen_way)
);
